@@ hdl/cdc_pkg.sv @@
// Package for the calendar date counter: opcodes, controller/datapath command
// and status structs, and the month-length and leap-year helpers.
// No dependencies.
package cdc_pkg;

   typedef enum logic [1:0] {
      OP_SET  = 2'd0,
      OP_PRE  = 2'd1,
      OP_POST = 2'd2,
      OP_ADD  = 2'd3
   } op_type;

   localparam int LEAP_CYCLE  = 400;
   localparam int CENTURY     = 100;
   localparam int MONTHS      = 12;
   localparam int FEB_LEAP    = 29;
   localparam int LONG_MONTH  = 31;
   localparam int RESET_DAY   = 1;
   localparam int RESET_MONTH = 1;
   localparam int RESET_YEAR  = 2000;
   localparam int MOD_W       = 9;
   localparam int DIGIT_BITS  = 4;

   typedef struct packed {
      logic load;
      logic mod_step;
      logic clamp;
      logic step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic req_set;
      logic digit_last;
      logic count_zero;
      logic out_free;
   } status_type;

   function automatic logic is_leap(input logic [MOD_W-1:0] mod400, input logic [1:0] low2);
      logic leap;
      leap = (mod400 == '0) ||
             ((low2 == 2'd0) && (mod400 != MOD_W'(CENTURY)) &&
              (mod400 != MOD_W'(2 * CENTURY)) && (mod400 != MOD_W'(3 * CENTURY)));
      return leap;
   endfunction

   function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      unique case (month)
         4'd2: begin
            len = leap ? 5'(FEB_LEAP) : 5'(FEB_LEAP - 1);
         end
         4'd4, 4'd6, 4'd9, 4'd11: begin
            len = 5'(LONG_MONTH - 1);
         end
         default: begin
            len = 5'(LONG_MONTH);
         end
      endcase
      return len;
   endfunction

endpackage

@@ hdl/cdc_req_if.sv @@
// Request channel of the calendar date counter: valid/ready plus the request word.
// Depends on nothing.
interface cdc_req_if #(
   parameter int YEAR_WIDTH  = 16,
   parameter int COUNT_WIDTH = 16
);
   logic                   valid;
   logic                   ready;
   logic [1:0]             opcode;
   logic [5:0]             set_day;
   logic [3:0]             set_month;
   logic [YEAR_WIDTH-1:0]  set_year;
   logic [COUNT_WIDTH-1:0] day_count;

   modport source (output valid, opcode, set_day, set_month, set_year, day_count,
                   input ready);
   modport sink   (input valid, opcode, set_day, set_month, set_year, day_count,
                   output ready);
endinterface

@@ hdl/cdc_rsp_if.sv @@
// Response channel of the calendar date counter: valid/ready plus the result word.
// Depends on nothing.
interface cdc_rsp_if #(
   parameter int YEAR_WIDTH = 16
);
   logic                  valid;
   logic                  ready;
   logic [4:0]            out_day;
   logic [3:0]            out_month;
   logic [YEAR_WIDTH-1:0] out_year;
   logic                  leap_flag;

   modport source (output valid, out_day, out_month, out_year, leap_flag, input ready);
   modport sink   (input valid, out_day, out_month, out_year, leap_flag, output ready);
endinterface

@@ hdl/cdc_ctrl.sv @@
// Controller of the calendar date counter: sequences reduce, clamp, advance and emit.
// Depends on cdc_pkg.
module cdc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  cdc_pkg::status_type   status,
   output cdc_pkg::cmd_type      cmd
);

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_REDUCE  = 5'b00010,
      ST_CLAMP   = 5'b00100,
      ST_ADVANCE = 5'b01000,
      ST_EMIT    = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.req_set ? ST_REDUCE : ST_ADVANCE;
            end
         end
         ST_REDUCE: begin
            cmd.mod_step = 1'b1;
            if (status.digit_last) begin
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            cmd.clamp = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_ADVANCE: begin
            if (status.count_zero) begin
               state_in = ST_EMIT;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hdl/cdc_dp.sv @@
// Datapath of the calendar date counter: stored date, working date, year mod 400
// reducer, day counter and output register. Depends on cdc_pkg.
module cdc_dp #(
   parameter int YEAR_WIDTH  = 16,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cdc_pkg::cmd_type       cmd,
   output cdc_pkg::status_type    status,
   input  logic [1:0]             req_opcode,
   input  logic [5:0]             req_set_day,
   input  logic [3:0]             req_set_month,
   input  logic [YEAR_WIDTH-1:0]  req_set_year,
   input  logic [COUNT_WIDTH-1:0] req_day_count,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [4:0]             rsp_out_day,
   output logic [3:0]             rsp_out_month,
   output logic [YEAR_WIDTH-1:0]  rsp_out_year,
   output logic                   rsp_leap_flag
);

   localparam int DIGITS = (YEAR_WIDTH + cdc_pkg::DIGIT_BITS - 1) / cdc_pkg::DIGIT_BITS;
   localparam int PAD_W  = DIGITS * cdc_pkg::DIGIT_BITS;
   localparam int DIG_W  = $clog2(DIGITS);
   localparam int MW     = cdc_pkg::MOD_W;

   logic [4:0]             cur_day_ff, cur_day_in;
   logic [3:0]             cur_month_ff, cur_month_in;
   logic [YEAR_WIDTH-1:0]  cur_year_ff, cur_year_in;
   logic [MW-1:0]          cur_mod_ff, cur_mod_in;

   cdc_pkg::op_type        op_ff;
   logic [5:0]             set_day_ff;
   logic [3:0]             set_month_ff;
   logic [4:0]             wrk_day_ff;
   logic [3:0]             wrk_month_ff;
   logic [YEAR_WIDTH-1:0]  wrk_year_ff;
   logic [MW-1:0]          wrk_mod_ff;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [PAD_W-1:0]       shift_ff;
   logic [MW-1:0]          rem_ff;
   logic [DIG_W-1:0]       digit_ff;

   logic                   out_valid_ff, out_valid_in;
   logic [4:0]             out_day_ff;
   logic [3:0]             out_month_ff;
   logic [YEAR_WIDTH-1:0]  out_year_ff;
   logic                   out_leap_ff;

   logic [4:0]             nx_day;
   logic [3:0]             nx_month;
   logic [YEAR_WIDTH-1:0]  nx_year;
   logic [MW-1:0]          nx_mod;
   logic [4:0]             wrk_len;

   logic [4:0]             cl_day;
   logic [3:0]             cl_month;
   logic [4:0]             cl_len;

   logic [MW-1:0]          rem_next;

   // Next calendar day of the working date.
   always_comb begin
      wrk_len  = cdc_pkg::days_in(wrk_month_ff, cdc_pkg::is_leap(wrk_mod_ff, wrk_year_ff[1:0]));
      nx_day   = wrk_day_ff + 5'd1;
      nx_month = wrk_month_ff;
      nx_year  = wrk_year_ff;
      nx_mod   = wrk_mod_ff;
      if (wrk_day_ff >= wrk_len) begin
         nx_day = 5'd1;
         if (wrk_month_ff >= 4'(cdc_pkg::MONTHS)) begin
            nx_month = 4'd1;
            nx_year  = wrk_year_ff + YEAR_WIDTH'(1);
            if (wrk_year_ff == '1) begin
               nx_mod = '0;
            end else if (wrk_mod_ff == MW'(cdc_pkg::LEAP_CYCLE - 1)) begin
               nx_mod = '0;
            end else begin
               nx_mod = wrk_mod_ff + MW'(1);
            end
         end else begin
            nx_month = wrk_month_ff + 4'd1;
         end
      end
   end

   // Clamp of a requested date; the year residue is ready in rem_ff.
   always_comb begin
      if (set_month_ff == 4'd0) begin
         cl_month = 4'd1;
      end else if (set_month_ff > 4'(cdc_pkg::MONTHS)) begin
         cl_month = 4'(cdc_pkg::MONTHS);
      end else begin
         cl_month = set_month_ff;
      end
      cl_len = cdc_pkg::days_in(cl_month, cdc_pkg::is_leap(rem_ff, wrk_year_ff[1:0]));
      if (set_day_ff == 6'd0) begin
         cl_day = 5'd1;
      end else if (set_day_ff > {1'b0, cl_len}) begin
         cl_day = cl_len;
      end else begin
         cl_day = set_day_ff[4:0];
      end
   end

   // Year modulo 400, four bits of the year per cycle, most significant first.
   always_comb begin
      logic [MW:0] trial;
      rem_next = rem_ff;
      for (int i = 0; i < cdc_pkg::DIGIT_BITS; i++) begin
         trial = {rem_next, shift_ff[PAD_W-1-i]};
         if (trial >= (MW + 1)'(cdc_pkg::LEAP_CYCLE)) begin
            trial = trial - (MW + 1)'(cdc_pkg::LEAP_CYCLE);
         end
         rem_next = trial[MW-1:0];
      end
   end

   always_comb begin
      cur_day_in   = cur_day_ff;
      cur_month_in = cur_month_ff;
      cur_year_in  = cur_year_ff;
      cur_mod_in   = cur_mod_ff;
      if (cmd.emit) begin
         unique case (op_ff)
            cdc_pkg::OP_SET, cdc_pkg::OP_PRE: begin
               cur_day_in   = wrk_day_ff;
               cur_month_in = wrk_month_ff;
               cur_year_in  = wrk_year_ff;
               cur_mod_in   = wrk_mod_ff;
            end
            cdc_pkg::OP_POST: begin
               cur_day_in   = nx_day;
               cur_month_in = nx_month;
               cur_year_in  = nx_year;
               cur_mod_in   = nx_mod;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (cmd.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_day_ff   <= 5'(cdc_pkg::RESET_DAY);
         cur_month_ff <= 4'(cdc_pkg::RESET_MONTH);
         cur_year_ff  <= YEAR_WIDTH'(cdc_pkg::RESET_YEAR);
         cur_mod_ff   <= MW'(cdc_pkg::RESET_YEAR % cdc_pkg::LEAP_CYCLE);
         out_valid_ff <= 1'b0;
      end else begin
         cur_day_ff   <= cur_day_in;
         cur_month_ff <= cur_month_in;
         cur_year_ff  <= cur_year_in;
         cur_mod_ff   <= cur_mod_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff        <= cdc_pkg::op_type'(req_opcode);
         set_day_ff   <= req_set_day;
         set_month_ff <= req_set_month;
         wrk_day_ff   <= cur_day_ff;
         wrk_month_ff <= cur_month_ff;
         wrk_year_ff  <= (req_opcode == cdc_pkg::OP_SET) ? req_set_year : cur_year_ff;
         wrk_mod_ff   <= cur_mod_ff;
         shift_ff     <= PAD_W'(req_set_year);
         rem_ff       <= '0;
         digit_ff     <= '0;
         unique case (cdc_pkg::op_type'(req_opcode))
            cdc_pkg::OP_PRE: begin
               count_ff <= COUNT_WIDTH'(1);
            end
            cdc_pkg::OP_ADD: begin
               count_ff <= req_day_count;
            end
            default: begin
               count_ff <= '0;
            end
         endcase
      end else if (cmd.mod_step) begin
         rem_ff   <= rem_next;
         shift_ff <= shift_ff << cdc_pkg::DIGIT_BITS;
         digit_ff <= digit_ff + DIG_W'(1);
      end else if (cmd.clamp) begin
         wrk_day_ff   <= cl_day;
         wrk_month_ff <= cl_month;
         wrk_mod_ff   <= rem_ff;
      end else if (cmd.step) begin
         wrk_day_ff   <= nx_day;
         wrk_month_ff <= nx_month;
         wrk_year_ff  <= nx_year;
         wrk_mod_ff   <= nx_mod;
         count_ff     <= count_ff - COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_day_ff   <= wrk_day_ff;
         out_month_ff <= wrk_month_ff;
         out_year_ff  <= wrk_year_ff;
         out_leap_ff  <= cdc_pkg::is_leap(wrk_mod_ff, wrk_year_ff[1:0]);
      end
   end

   assign status.req_set    = (req_opcode == cdc_pkg::OP_SET);
   assign status.digit_last = (digit_ff == DIG_W'(DIGITS - 1));
   assign status.count_zero = (count_ff == '0);
   assign status.out_free   = !out_valid_ff || rsp_ready;

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_day   = out_day_ff;
   assign rsp_out_month = out_month_ff;
   assign rsp_out_year  = out_year_ff;
   assign rsp_leap_flag = out_leap_ff;

endmodule

@@ hdl/calendar_date_counter_top.sv @@
// Top level of the calendar date counter: joins the controller and the datapath
// to the request and response channels. Depends on cdc_pkg, cdc_req_if, cdc_rsp_if.
//
//   Channel   Direction  Word
//   req_bus   in         opcode, set_day, set_month, set_year, day_count
//   rsp_bus   out        out_day, out_month, out_year, leap_flag
//
// A set runs the year mod 400 reducer over the year, then clamps the date and emits it.
// Pre-increment steps the date once, post-increment emits it and then steps, and add
// steps day_count times; the date advances one day per cycle.
// Reset loads January 1, 2000 at once and needs no clearing pass.
// The result waits in an output register; a new request word is taken while it
// waits, and the block holds before its own result until that register frees.
module calendar_date_counter_top #(
   parameter int YEAR_WIDTH  = 16,
   parameter int COUNT_WIDTH = 16
) (
   input logic      clock,
   input logic      reset,
   cdc_req_if.sink  req_bus,
   cdc_rsp_if.source rsp_bus
);

   cdc_pkg::cmd_type    cmd;
   cdc_pkg::status_type status;

   cdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   cdc_dp #(
      .YEAR_WIDTH  (YEAR_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_opcode    (req_bus.opcode),
      .req_set_day   (req_bus.set_day),
      .req_set_month (req_bus.set_month),
      .req_set_year  (req_bus.set_year),
      .req_day_count (req_bus.day_count),
      .rsp_ready     (rsp_bus.ready),
      .rsp_valid     (rsp_bus.valid),
      .rsp_out_day   (rsp_bus.out_day),
      .rsp_out_month (rsp_bus.out_month),
      .rsp_out_year  (rsp_bus.out_year),
      .rsp_leap_flag (rsp_bus.leap_flag)
   );

endmodule

@@ hdl/cdc_checker.sv @@
// Port-level checks for the calendar date counter, attached by a bind statement.
// Depends on calendar_date_counter_top.
module cdc_checker #(
   parameter int YEAR_WIDTH = 16
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [4:0]            rsp_out_day,
   input logic [3:0]            rsp_out_month,
   input logic [YEAR_WIDTH-1:0] rsp_out_year,
   input logic                  rsp_leap_flag
);

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Response word valid right after reset.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("Response word dropped before it was taken.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_day != 5'd0 && rsp_out_month != 4'd0 && rsp_out_month <= 4'd12)
      else $error("Response date out of range.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_year[1:0] != 2'd0 |-> !rsp_leap_flag)
      else $error("Leap flag set for a year not divisible by four.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_month == 4'd2 |-> rsp_out_day <= 5'd29)
      else $error("February day beyond the 29th.");

endmodule

bind calendar_date_counter_top cdc_checker #(
   .YEAR_WIDTH (YEAR_WIDTH)
) u_cdc_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_out_day   (rsp_bus.out_day),
   .rsp_out_month (rsp_bus.out_month),
   .rsp_out_year  (rsp_bus.out_year),
   .rsp_leap_flag (rsp_bus.leap_flag)
);

@@ bench/calendar_date_counter_top_tb.sv @@
`timescale 1ns / 100ps
// Testbench for calendar_date_counter_top: a directed table and a long random run go
// through the request channel, and every response word is checked against the table's result or a date predictor.
// Depends on cdc_pkg, cdc_req_if, cdc_rsp_if and calendar_date_counter_top.
module calendar_date_counter_top_tb;

   localparam int YEAR_WIDTH = 16;
   localparam int COUNT_WIDTH = 16;
   localparam int YEAR_SPAN = 1 << YEAR_WIDTH;
   localparam int RANDOM_WORDS = 1300;
   localparam int MAX_LONG_ADDS = 6;
   localparam int HOLD_AFTER_WORDS = 300;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 50;
   localparam int TABLE_ROWS = 24;
   localparam longint CYCLE_LIMIT = 6000000;

   typedef struct packed {
      logic [4:0] day;
      logic [3:0] month;
      logic [15:0] year;
      logic leap;
   } date_word;

   typedef struct {
      int unsigned day;
      int unsigned month;
      int unsigned year;
   } cal_date;

   typedef struct packed {
      cdc_pkg::op_type op;
      logic [5:0] day;
      logic [3:0] month;
      logic [15:0] year;
      logic [15:0] count;
      logic fixed;
      date_word result;
   } table_row;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic calm = 1'b0;
   logic hold_rsp = 1'b0;
   int words_sent = 0;
   int words_seen = 0;
   int mismatches = 0;
   longint cycle_count = 0;
   cal_date held_date = '{1, 1, 2000};
   date_word pending_dates[$];

   table_row directed_dates [TABLE_ROWS] = '{
      '{cdc_pkg::OP_POST, 6'd0, 4'd0, 16'd0, 16'd0, 1'b1, '{5'd1, 4'd1, 16'd2000, 1'b1}},
      '{cdc_pkg::OP_PRE, 6'd0, 4'd0, 16'd0, 16'd0, 1'b1, '{5'd3, 4'd1, 16'd2000, 1'b1}},
      '{cdc_pkg::OP_ADD, 6'd0, 4'd0, 16'd0, 16'd0, 1'b1, '{5'd3, 4'd1, 16'd2000, 1'b1}},
      '{cdc_pkg::OP_SET, 6'd0, 4'd0, 16'd0, 16'd0, 1'b1, '{5'd1, 4'd1, 16'd0, 1'b1}},
      '{cdc_pkg::OP_SET, 6'd63, 4'd15, 16'd65535, 16'd0, 1'b1,
        '{5'd31, 4'd12, 16'd65535, 1'b0}},
      '{cdc_pkg::OP_PRE, 6'd0, 4'd0, 16'd0, 16'd0, 1'b1, '{5'd1, 4'd1, 16'd0, 1'b1}},
      '{cdc_pkg::OP_SET, 6'd63, 4'd2, 16'd2000, 16'd0, 1'b1, '{5'd29, 4'd2, 16'd2000, 1'b1}},
      '{cdc_pkg::OP_SET, 6'd63, 4'd2, 16'd1900, 16'd0, 1'b1, '{5'd28, 4'd2, 16'd1900, 1'b0}},
      '{cdc_pkg::OP_SET, 6'd30, 4'd2, 16'd2024, 16'd0, 1'b1, '{5'd29, 4'd2, 16'd2024, 1'b1}},
      '{cdc_pkg::OP_SET, 6'd31, 4'd4, 16'd2023, 16'd0, 1'b1, '{5'd30, 4'd4, 16'd2023, 1'b0}},
      '{cdc_pkg::OP_SET, 6'd28, 4'd2, 16'd2100, 16'd0, 1'b1, '{5'd28, 4'd2, 16'd2100, 1'b0}},
      '{cdc_pkg::OP_PRE, 6'd0, 4'd0, 16'd0, 16'd0, 1'b1, '{5'd1, 4'd3, 16'd2100, 1'b0}},
      '{cdc_pkg::OP_SET, 6'd28, 4'd2, 16'd2024, 16'd0, 1'b1, '{5'd28, 4'd2, 16'd2024, 1'b1}},
      '{cdc_pkg::OP_POST, 6'd0, 4'd0, 16'd0, 16'd0, 1'b1, '{5'd28, 4'd2, 16'd2024, 1'b1}},
      '{cdc_pkg::OP_PRE, 6'd0, 4'd0, 16'd0, 16'd0, 1'b1, '{5'd1, 4'd3, 16'd2024, 1'b1}},
      '{cdc_pkg::OP_SET, 6'd31, 4'd12, 16'd65535, 16'd0, 1'b1,
        '{5'd31, 4'd12, 16'd65535, 1'b0}},
      '{cdc_pkg::OP_ADD, 6'd0, 4'd0, 16'd0, 16'd1, 1'b1, '{5'd1, 4'd1, 16'd0, 1'b1}},
      '{cdc_pkg::OP_POST, 6'd0, 4'd0, 16'd0, 16'd0, 1'b1, '{5'd31, 4'd12, 16'd65535, 1'b0}},
      '{cdc_pkg::OP_POST, 6'd0, 4'd0, 16'd0, 16'd0, 1'b1, '{5'd1, 4'd1, 16'd0, 1'b1}},
      '{cdc_pkg::OP_SET, 6'd0, 4'd13, 16'd1999, 16'd0, 1'b1, '{5'd1, 4'd12, 16'd1999, 1'b0}},
      '{cdc_pkg::OP_ADD, 6'd0, 4'd0, 16'd0, 16'd65535, 1'b0, '{5'd0, 4'd0, 16'd0, 1'b0}},
      '{cdc_pkg::OP_ADD, 6'd0, 4'd0, 16'd0, 16'd366, 1'b0, '{5'd0, 4'd0, 16'd0, 1'b0}},
      '{cdc_pkg::OP_SET, 6'd42, 4'd10, 16'd43690, 16'd0, 1'b1,
        '{5'd31, 4'd10, 16'd43690, 1'b0}},
      '{cdc_pkg::OP_SET, 6'd21, 4'd5, 16'd21845, 16'd0, 1'b1,
        '{5'd21, 4'd5, 16'd21845, 1'b0}}
   };

   cdc_req_if #(.YEAR_WIDTH(YEAR_WIDTH), .COUNT_WIDTH(COUNT_WIDTH)) req_bus ();
   cdc_rsp_if #(.YEAR_WIDTH(YEAR_WIDTH)) rsp_bus ();

   calendar_date_counter_top #(
      .YEAR_WIDTH(YEAR_WIDTH),
      .COUNT_WIDTH(COUNT_WIDTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   always #5 clock = ~clock;

   function automatic bit leap_year(input int unsigned year);
      return (year % 400 == 0) || (year % 4 == 0 && year % 100 != 0);
   endfunction

   function automatic int unsigned month_days(input int unsigned month, input int unsigned year);
      int unsigned len;
      case (month)
         2: begin
            len = leap_year(year) ? 29 : 28;
         end
         4, 6, 9, 11: begin
            len = 30;
         end
         default: begin
            len = 31;
         end
      endcase
      return len;
   endfunction

   function automatic cal_date day_after(input cal_date d);
      cal_date n;
      n = d;
      n.day = n.day + 1;
      if (n.day > month_days(n.month, n.year)) begin
         n.day = 1;
         n.month = n.month + 1;
         if (n.month > 12) begin
            n.month = 1;
            n.year = (n.year + 1) % YEAR_SPAN;
         end
      end
      return n;
   endfunction

   // Applies one request word to the held date and returns the response word it yields.
   function automatic date_word predict_date(input table_row row);
      cal_date r;
      int unsigned limit;
      date_word w;
      case (row.op)
         cdc_pkg::OP_SET: begin
            r.month = int'(row.month);
            if (r.month < 1) r.month = 1;
            else if (r.month > 12) r.month = 12;
            r.year = int'(row.year);
            limit = month_days(r.month, r.year);
            r.day = int'(row.day);
            if (r.day < 1) r.day = 1;
            else if (r.day > limit) r.day = limit;
            held_date = r;
         end
         cdc_pkg::OP_PRE: begin
            r = day_after(held_date);
            held_date = r;
         end
         cdc_pkg::OP_POST: begin
            r = held_date;
            held_date = day_after(r);
         end
         default: begin
            r = held_date;
            for (int k = 0; k < int'(row.count); k++) r = day_after(r);
         end
      endcase
      w.day = 5'(r.day);
      w.month = 4'(r.month);
      w.year = 16'(r.year);
      w.leap = leap_year(r.year);
      return w;
   endfunction

   function automatic int idle_length();
      int pick;
      if (calm) return 0;
      pick = int'($urandom_range(0, 99));
      if (pick < 55) return 0;
      if (pick < 85) return int'($urandom_range(1, 3));
      if (pick < 97) return int'($urandom_range(4, 15));
      return int'($urandom_range(30, 120));
   endfunction

   task automatic offer_word(input table_row row);
      int gap;
      date_word predicted;
      gap = idle_length();
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.opcode = row.op;
      req_bus.set_day = row.day;
      req_bus.set_month = row.month;
      req_bus.set_year = row.year;
      req_bus.day_count = row.count;
      req_bus.valid = 1'b1;
      forever begin
         @(posedge clock);
         if (req_bus.ready) break;
      end
      predicted = predict_date(row);
      pending_dates.push_back(row.fixed ? row.result : predicted);
      words_sent++;
      @(negedge clock);
   endtask

   initial begin : stimulus
      table_row row;
      int long_adds;
      req_bus.valid = 1'b0;
      req_bus.opcode = cdc_pkg::OP_SET;
      req_bus.set_day = '0;
      req_bus.set_month = '0;
      req_bus.set_year = '0;
      req_bus.day_count = '0;
      long_adds = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_dates[i]) offer_word(directed_dates[i]);

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i % 64 == 0) calm = ($urandom_range(0, 3) == 0);
         row = '0;
         row.op = cdc_pkg::op_type'($urandom_range(0, 3));
         row.day = 6'($urandom_range(0, 63));
         row.month = 4'($urandom_range(0, 15));
         row.year = 16'($urandom_range(0, 65535));
         row.count = 16'($urandom_range(0, 399));
         if (row.op == cdc_pkg::OP_SET) begin
            case ($urandom_range(0, 4))
               0, 1: row.day = 6'($urandom_range(1, 28));
               2, 3: row.day = 6'($urandom_range(27, 31));
               default: row.day = 6'($urandom_range(0, 63));
            endcase
            case ($urandom_range(0, 5))
               0: row.month = 4'd2;
               1: row.month = 4'd12;
               2: row.month = 4'($urandom_range(0, 15));
               default: row.month = 4'($urandom_range(1, 12));
            endcase
            case ($urandom_range(0, 9))
               0: row.year = 16'd1600;
               1: row.year = 16'd1900;
               2: row.year = 16'd2000;
               3: row.year = 16'd2023;
               4: row.year = 16'd2024;
               5: row.year = 16'd2100;
               6: row.year = 16'($urandom_range(0, 3));
               7: row.year = 16'(65535 - $urandom_range(0, 5));
               default: row.year = 16'($urandom_range(0, 65535));
            endcase
         end else if (row.op == cdc_pkg::OP_ADD && long_adds < MAX_LONG_ADDS &&
                      $urandom_range(0, 63) == 0) begin
            row.count = 16'($urandom_range(0, 65535));
            long_adds++;
         end
         offer_word(row);
      end
      req_bus.valid = 1'b0;

      while (pending_dates.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("** calendar_date_counter_top: PASSED **");
      end else begin
         $display("** calendar_date_counter_top: FAILED **");
      end
      $finish;
   end

   initial begin : rsp_side
      int stall;
      stall = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall > 0) stall--;
         else if ($urandom_range(0, 3) == 0) stall = idle_length();
         rsp_bus.ready = !hold_rsp && (stall == 0);
      end
   end

   // The receiver stops for a long stretch while words keep coming, so the block backs up.
   initial begin : long_hold
      wait (words_sent >= HOLD_AFTER_WORDS);
      @(posedge clock);
      hold_rsp = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp = 1'b0;
   end

   always @(posedge clock) begin : check_words
      date_word want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         words_seen++;
         if (pending_dates.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("response word %0d arrived with nothing expected", words_seen);
            end
         end else begin
            want = pending_dates.pop_front();
            if (rsp_bus.out_day !== want.day || rsp_bus.out_month !== want.month ||
                rsp_bus.out_year !== want.year || rsp_bus.leap_flag !== want.leap) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display({"response word %0d: expected %0d/%0d/%0d leap %0b, ",
                            "got %0d/%0d/%0d leap %0b"},
                           words_seen, want.day, want.month, want.year, want.leap,
                           rsp_bus.out_day, rsp_bus.out_month, rsp_bus.out_year,
                           rsp_bus.leap_flag);
               end
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** calendar_date_counter_top: FAILED **");
         $finish;
      end
   end

endmodule
